[rtl/substring_first_match_defines.svh]
// Assertion macros for the substring first-match block.
// Used by the top level; expects clk and arst_n in scope.
`ifndef SUBSTRING_FIRST_MATCH_DEFINES_SVH
`define SUBSTRING_FIRST_MATCH_DEFINES_SVH

// same-cycle implication
`define SFM_ASSERT_NOW(label, cond, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (expr)) \
		else $error(msg);

// next-cycle implication
`define SFM_ASSERT_NEXT(label, cond, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (expr)) \
		else $error(msg);

`endif

[rtl/sfm_pkg.sv]
// Shared types and constants for the substring first-match block.
// No dependencies.
package sfm_pkg;

	localparam int MaxLenDef = 64;

	localparam logic [1:0] OP_PAT   = 2'd0;
	localparam logic [1:0] OP_TEXT  = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	localparam logic [1:0] ST_FOUND    = 2'd0;
	localparam logic [1:0] ST_NOTFOUND = 2'd1;
	localparam logic [1:0] ST_BADARG   = 2'd2;

	typedef struct packed {
		logic [1:0] opcode;
		logic [7:0] char_code;
		logic       last;
		logic [6:0] start_position;
	} item_t;

	typedef struct packed {
		logic [1:0] status;
		logic [6:0] match_position;
	} result_t;

	typedef struct packed {
		logic       load;
		logic       step;
		logic       clear;
		logic [7:0] chr;
	} cell_ctrl_t;

endpackage

[rtl/sfm_cell.sv]
// One cell of the match chain: a pattern byte and its partial-match bit.
// Depends on sfm_pkg.
module sfm_cell #(
	parameter int IDX = 0,
	parameter int LW  = 7
) (
	input  logic               clk,
	input  logic               arst_n,
	input  sfm_pkg::cell_ctrl_t ctrl,
	input  logic [LW-1:0]      len,
	input  logic [LW-1:0]      wr_idx,
	input  logic               prev,
	output logic               match,
	output logic               hit
);

	localparam logic [LW-1:0] IdxL    = LW'(IDX);
	localparam logic [LW-1:0] IdxNext = LW'(IDX + 1);

	logic [7:0] chr_q;
	logic       match_q;
	logic       active;
	logic       tail;
	logic       nxt;

	assign active = IdxL < len;
	assign tail   = IdxNext == len;
	assign nxt    = prev & (ctrl.chr == chr_q);
	assign hit    = ctrl.step & active & tail & nxt;
	assign match  = match_q;

	always_ff @(posedge clk) begin
		if (ctrl.load && wr_idx == IdxL) begin
			chr_q <= ctrl.chr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else if (ctrl.clear) begin
			match_q <= 1'b0;
		end else if (ctrl.step && active) begin
			match_q <= nxt;
		end
	end

endmodule

[rtl/substring_first_match.sv]
// Top level of the substring first-match block: control and cell chain.
// Depends on sfm_pkg, sfm_cell and substring_first_match_defines.svh.
//
// Usage: the item channel (item_valid, item_stall, item) carries one word per
// pattern byte, text byte or pattern clear. Pattern bytes load cells in order;
// text bytes go to a chain of MAX_LEN cells that all compare in the same cycle
// and hand their match bits to the next cell, so one item is taken every cycle
// while item_stall is low. The word that marks the last text byte yields one
// result word on the result channel (result_valid, result_stall, result) in the
// cycle after it: found with the 1-based start of the leftmost match, not found,
// or bad argument. Other items yield no result. The result is held in the result
// register, and every cell updates in one step.
// A held result sits in the output register; item_stall rises only while that
// register is full and result_stall is high, so a result taken every cycle
// never slows the input.
// Reset clears the pattern length, the search state and the output valid;
// pattern bytes need no reset and are rewritten before use.
`include "substring_first_match_defines.svh"

module substring_first_match #(
	parameter int MAX_LEN = sfm_pkg::MaxLenDef
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  sfm_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_stall,
	output sfm_pkg::result_t result
);

	localparam int CW = $clog2(MAX_LEN + 1);
	localparam int FW = (CW > 7) ? CW : 7;
	localparam logic [CW-1:0] MaxL = CW'(MAX_LEN);

	logic [CW-1:0] len_q;
	logic          open_q;
	logic [CW-1:0] cnt_q;
	logic [6:0]    start_q;
	logic          found_q;
	logic [CW-1:0] found_at_q;
	logic             result_valid_q;
	sfm_pkg::result_t result_q;

	logic          acc;
	logic          is_pat;
	logic          is_text;
	logic          is_clr;
	logic          room;
	logic [CW-1:0] wr_base;
	logic [CW-1:0] pos;
	logic [CW-1:0] cnt_new;
	logic [6:0]    start_eff;
	logic          start_ok;
	logic          hit_any;
	logic          found_new;
	logic [CW-1:0] found_at_new;
	logic          found_eff;
	logic [CW-1:0] found_at_eff;
	logic [FW-1:0] found_at_ext;
	logic          bad_arg;
	logic          emit;
	sfm_pkg::cell_ctrl_t ctrl;
	logic [MAX_LEN-1:0]  match_w;
	logic [MAX_LEN-1:0]  hit_w;
	logic [MAX_LEN-1:0]  prev_w;

	assign item_stall   = result_valid_q & result_stall;
	assign acc          = item_valid & ~item_stall;
	assign is_pat       = item.opcode == sfm_pkg::OP_PAT;
	assign is_text      = item.opcode == sfm_pkg::OP_TEXT;
	assign is_clr       = item.opcode == sfm_pkg::OP_CLEAR;
	assign room         = cnt_q < MaxL;
	assign wr_base      = open_q ? len_q : '0;
	assign pos          = cnt_q + CW'(1);
	assign cnt_new      = room ? pos : cnt_q;
	assign start_eff    = (cnt_q == '0) ? item.start_position : start_q;
	assign start_ok     = FW'(pos) >= FW'(start_eff);
	assign hit_any      = |hit_w;
	assign found_new    = ctrl.step & ~found_q & hit_any;
	assign found_at_new = pos - len_q + CW'(1);
	assign found_eff    = found_q | found_new;
	assign found_at_eff = found_q ? found_at_q : found_at_new;
	assign found_at_ext = FW'(found_at_eff);
	assign bad_arg      = (start_eff == 7'd0) || (FW'(start_eff) > FW'(cnt_new)) ||
		(len_q == '0);
	assign emit         = acc & is_text & item.last;

	assign ctrl.load  = acc & is_pat & (wr_base < MaxL);
	assign ctrl.step  = acc & is_text & room;
	assign ctrl.clear = emit | (acc & (is_pat | is_clr) & (cnt_q != '0));
	assign ctrl.chr   = item.char_code;

	assign prev_w[0] = start_ok;

	genvar k;
	generate
		for (k = 1; k < MAX_LEN; k++) begin : g_prev
			assign prev_w[k] = match_w[k-1];
		end
		for (k = 0; k < MAX_LEN; k++) begin : g_cell
			sfm_cell #(
				.IDX(k),
				.LW (CW)
			) u_cell (
				.clk   (clk),
				.arst_n(arst_n),
				.ctrl  (ctrl),
				.len   (len_q),
				.wr_idx(wr_base),
				.prev  (prev_w[k]),
				.match (match_w[k]),
				.hit   (hit_w[k])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q          <= '0;
			open_q         <= 1'b0;
			cnt_q          <= '0;
			start_q        <= '0;
			found_q        <= 1'b0;
			found_at_q     <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
			if (acc) begin
				case (item.opcode)
					sfm_pkg::OP_PAT: begin
						len_q  <= ctrl.load ? (wr_base + CW'(1)) : wr_base;
						open_q <= ~item.last;
					end
					sfm_pkg::OP_CLEAR: begin
						len_q  <= '0;
						open_q <= 1'b0;
					end
					sfm_pkg::OP_TEXT: begin
						open_q <= 1'b0;
					end
					default: begin
					end
				endcase
				if (ctrl.clear) begin
					cnt_q      <= '0;
					start_q    <= '0;
					found_q    <= 1'b0;
					found_at_q <= '0;
				end else if (is_text) begin
					cnt_q   <= cnt_new;
					start_q <= start_eff;
					if (found_new) begin
						found_q    <= 1'b1;
						found_at_q <= found_at_new;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			if (bad_arg) begin
				result_q.status         <= sfm_pkg::ST_BADARG;
				result_q.match_position <= '0;
			end else if (found_eff) begin
				result_q.status         <= sfm_pkg::ST_FOUND;
				result_q.match_position <= found_at_ext[6:0];
			end else begin
				result_q.status         <= sfm_pkg::ST_NOTFOUND;
				result_q.match_position <= '0;
			end
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	`SFM_ASSERT_NEXT(a_emit_valid, emit, result_valid, "result missing after last text word")
	`SFM_ASSERT_NOW(a_found_cnt, found_q, cnt_q != '0, "match flag set with no text")
	`SFM_ASSERT_NOW(a_open_len, open_q, len_q != '0, "open pattern load with zero length")
	`SFM_ASSERT_NOW(a_miss_pos,
		result_valid && result.status != sfm_pkg::ST_FOUND,
		result.match_position == 7'd0, "nonzero position without a match")

endmodule
